/* design/gbls_pkg.sv */
// Package for the load/store unit: bus access codes, result record and decode helpers.
// No dependencies.
package gbls_pkg;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } access_t;

  typedef enum logic [1:0] {
    STEP_IDLE   = 2'd0,
    STEP_FIRST  = 2'd1,
    STEP_SECOND = 2'd2
  } step_t;

  typedef struct packed {
    logic       not_load;
    logic       done_res;
    logic [2:0] cycles;
    logic [1:0] imm_bytes;
    logic [7:0] write_data;
    logic [15:0] address;
    logic [1:0] access;
  } res_t;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_LD_MHL_N = 8'h36;
  localparam logic [7:0] OP_LD_NN_SP = 8'h08;
  localparam logic [7:0] OP_LD_BC_A = 8'h02;
  localparam logic [7:0] OP_LD_DE_A = 8'h12;
  localparam logic [7:0] OP_LDI_HL_A = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_A_BC = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE = 8'h1A;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_LDD_A_HL = 8'h3A;
  localparam logic [7:0] OP_LDH_N_A = 8'hE0;
  localparam logic [7:0] OP_LDH_C_A = 8'hE2;
  localparam logic [7:0] OP_LD_NN_A = 8'hEA;
  localparam logic [7:0] OP_LDH_A_N = 8'hF0;
  localparam logic [7:0] OP_LDH_A_C = 8'hF2;
  localparam logic [7:0] OP_LD_A_NN = 8'hFA;
  localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;
  localparam logic [7:0] OP_LD_SP_HL = 8'hF9;

  function automatic res_t mk_res(logic [1:0] acc, logic [15:0] addr, logic [7:0] wd,
                                  logic [1:0] imm, logic [2:0] cyc, logic dn, logic nl);
    res_t r;
    r.access = acc; r.address = addr; r.write_data = wd;
    r.imm_bytes = imm; r.cycles = cyc; r.done_res = dn; r.not_load = nl;
    return r;
  endfunction

  function automatic logic is_pop(logic [7:0] op);
    return (op & 8'hCF) == 8'hC1;
  endfunction

endpackage

/* design/gbls_out_buf.sv */
// Four-entry result queue that decouples the result channel from the core.
// Depends on gbls_pkg.
module gbls_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_one,
  input  logic            push_two,
  input  gbls_pkg::res_t  res0,
  input  gbls_pkg::res_t  res1,
  output logic            room,
  output logic            out_tvalid,
  input  logic            out_tready,
  output gbls_pkg::res_t  out_res
);
  gbls_pkg::res_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = cnt_r != 3'd0;
  assign out_res    = q_r[rd_r];
  // room for a two-result item even if nothing leaves this cycle
  assign room       = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (pop) rd_r <= rd_r + 2'd1;
      if (push_two) wr_r <= wr_r + 2'd2;
      else if (push_one) wr_r <= wr_r + 2'd1;
      cnt_r <= cnt_r + (push_two ? 3'd2 : {2'b0, push_one}) - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_one || push_two) q_r[wr_r] <= res0;
    if (push_two) q_r[wr_r + 2'd1] <= res1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_one || push_two) |-> room) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 3'd0) else $error("pop on empty");
`endif
endmodule

/* design/gb_cpu_load_store_unit.sv */
// Load/store/push/pop unit of an 8-bit handheld CPU core.
// An item is decoded in the cycle it is accepted and its results are written into the
// result queue. One item per cycle is taken while the result side keeps up; a
// four-entry result queue absorbs stalls and drops in_tready when two slots are not free.
// Reset (rst_n low, synchronous) clears all registers, the pending read and the queue.
module gb_cpu_load_store_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // opcode[7:0], imm_low[15:8], imm_high[23:16], read_data[31:24]
  input  logic        in_tuser,  // kind: 0 instruction, 1 read data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // access[1:0], address[17:2], write_data[25:18],
                                 // imm_bytes[27:26], cycles[30:28], not_load[31]
  ,output logic       out_tlast  // done_res
);
  localparam logic [1:0] NONE = gbls_pkg::ACC_NONE;
  localparam logic [1:0] RD   = gbls_pkg::ACC_READ;
  localparam logic [1:0] WR   = gbls_pkg::ACC_WRITE;

  // architectural state
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  r_r [6];
  logic [7:0]  r_nxt [6];
  logic [3:0]  f_r, f_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [7:0]  pop_r, pop_nxt;
  gbls_pkg::step_t step_r, step_nxt;

  logic kind;
  logic [7:0] op, n, dat;
  logic [15:0] nn, hl, bc, de;
  logic [2:0] d, s;
  logic [1:0] pi;
  logic [7:0] src;
  logic acc_in;
  logic push_one, push_two, room;
  gbls_pkg::res_t res0, res1, ores;
  logic [4:0] h_sum;
  logic [8:0] c_sum;
  logic [15:0] spe;

  assign kind = in_tuser;
  assign op   = in_tdata[7:0];
  assign n    = in_tdata[15:8];
  assign nn   = in_tdata[23:8];
  assign dat  = in_tdata[31:24];
  assign in_tready = room;
  assign acc_in = in_tvalid && in_tready;
  assign hl = {r_r[4], r_r[5]};
  assign bc = {r_r[0], r_r[1]};
  assign de = {r_r[2], r_r[3]};
  assign d  = op[5:3];
  assign s  = op[2:0];
  assign pi = op[5:4];

  always_comb begin
    case (s)
      3'd7: src = a_r;
      3'd6: src = 8'h00;
      default: src = r_r[s];
    endcase
  end

  // LD HL,SP+e: flags from unsigned carries of the low nibble and low byte
  assign h_sum = {1'b0, sp_r[3:0]} + {1'b0, n[3:0]};
  assign c_sum = {1'b0, sp_r[7:0]} + {1'b0, n};
  assign spe   = sp_r + {{8{n[7]}}, n};

  always_comb begin
    a_nxt = a_r; f_nxt = f_r; sp_nxt = sp_r; pop_nxt = pop_r; step_nxt = step_r;
    for (int i = 0; i < 6; i++) r_nxt[i] = r_r[i];
    res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd0, 1'b1, 1'b0);
    res1 = res0;
    push_one = 1'b0; push_two = 1'b0;
    if (acc_in && !kind) begin
      step_nxt = gbls_pkg::STEP_IDLE; pop_nxt = 8'h00;
      push_one = 1'b1;
      if (op[7:6] == 2'b01 && op != gbls_pkg::OP_HALT) begin
        if (d == 3'd6) res0 = gbls_pkg::mk_res(WR, hl, src, 2'd0, 3'd2, 1'b1, 1'b0);
        else if (s == 3'd6) begin
          res0 = gbls_pkg::mk_res(RD, hl, 8'h0, 2'd0, 3'd0, 1'b0, 1'b0);
          pop_nxt = op; step_nxt = gbls_pkg::STEP_FIRST;
        end else begin
          if (d == 3'd7) a_nxt = src; else r_nxt[d] = src;
          res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd1, 1'b1, 1'b0);
        end
      end else if ((op & 8'hC7) == 8'h06 && op != gbls_pkg::OP_LD_MHL_N) begin
        if (d == 3'd7) a_nxt = n; else r_nxt[d] = n;
        res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd1, 3'd2, 1'b1, 1'b0);
      end else if ((op & 8'hCF) == 8'h01) begin
        if (pi == 2'd3) sp_nxt = nn;
        else begin r_nxt[{pi, 1'b0}] = nn[15:8]; r_nxt[{pi, 1'b1}] = nn[7:0]; end
        res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd2, 3'd3, 1'b1, 1'b0);
      end else if (gbls_pkg::is_pop(op)) begin
        sp_nxt = sp_r + 16'd1;
        res0 = gbls_pkg::mk_res(RD, sp_r, 8'h0, 2'd0, 3'd0, 1'b0, 1'b0);
        pop_nxt = op; step_nxt = gbls_pkg::STEP_FIRST;
      end else if ((op & 8'hCF) == 8'hC5) begin
        push_one = 1'b0; push_two = 1'b1;
        sp_nxt = sp_r - 16'd2;
        res0 = gbls_pkg::mk_res(WR, sp_r - 16'd1,
                 (pi == 2'd3) ? a_r : r_r[{pi, 1'b0}], 2'd0, 3'd0, 1'b0, 1'b0);
        res1 = gbls_pkg::mk_res(WR, sp_r - 16'd2,
                 (pi == 2'd3) ? {f_r, 4'h0} : r_r[{pi, 1'b1}], 2'd0, 3'd4, 1'b1, 1'b0);
      end else begin
        case (op)
          gbls_pkg::OP_LD_BC_A: res0 = gbls_pkg::mk_res(WR, bc, a_r, 2'd0, 3'd2, 1'b1, 1'b0);
          gbls_pkg::OP_LD_DE_A: res0 = gbls_pkg::mk_res(WR, de, a_r, 2'd0, 3'd2, 1'b1, 1'b0);
          gbls_pkg::OP_LDI_HL_A, gbls_pkg::OP_LDD_HL_A: begin
            res0 = gbls_pkg::mk_res(WR, hl, a_r, 2'd0, 3'd2, 1'b1, 1'b0);
            {r_nxt[4], r_nxt[5]} = op[4] ? hl - 16'd1 : hl + 16'd1;
          end
          gbls_pkg::OP_LD_MHL_N: res0 = gbls_pkg::mk_res(WR, hl, n, 2'd1, 3'd3, 1'b1, 1'b0);
          gbls_pkg::OP_LD_NN_SP: begin
            push_one = 1'b0; push_two = 1'b1;
            res0 = gbls_pkg::mk_res(WR, nn, sp_r[7:0], 2'd0, 3'd0, 1'b0, 1'b0);
            res1 = gbls_pkg::mk_res(WR, nn + 16'd1, sp_r[15:8], 2'd2, 3'd5, 1'b1, 1'b0);
          end
          gbls_pkg::OP_LD_A_BC, gbls_pkg::OP_LD_A_DE, gbls_pkg::OP_LDI_A_HL,
          gbls_pkg::OP_LDD_A_HL, gbls_pkg::OP_LDH_A_N, gbls_pkg::OP_LDH_A_C,
          gbls_pkg::OP_LD_A_NN: begin
            pop_nxt = op; step_nxt = gbls_pkg::STEP_FIRST;
            case (op)
              gbls_pkg::OP_LD_A_BC: res0.address = bc;
              gbls_pkg::OP_LD_A_DE: res0.address = de;
              gbls_pkg::OP_LDI_A_HL: begin
                res0.address = hl; {r_nxt[4], r_nxt[5]} = hl + 16'd1;
              end
              gbls_pkg::OP_LDD_A_HL: begin
                res0.address = hl; {r_nxt[4], r_nxt[5]} = hl - 16'd1;
              end
              gbls_pkg::OP_LDH_A_N: res0.address = gbls_pkg::HIGH_PAGE | {8'h00, n};
              gbls_pkg::OP_LDH_A_C: res0.address = gbls_pkg::HIGH_PAGE | {8'h00, r_r[1]};
              default: res0.address = nn;
            endcase
            res0.access = RD; res0.done_res = 1'b0;
          end
          gbls_pkg::OP_LDH_N_A: res0 = gbls_pkg::mk_res(WR, gbls_pkg::HIGH_PAGE | {8'h00, n},
                                       a_r, 2'd1, 3'd3, 1'b1, 1'b0);
          gbls_pkg::OP_LDH_C_A: res0 = gbls_pkg::mk_res(WR,
                                       gbls_pkg::HIGH_PAGE | {8'h00, r_r[1]},
                                       a_r, 2'd0, 3'd2, 1'b1, 1'b0);
          gbls_pkg::OP_LD_NN_A: res0 = gbls_pkg::mk_res(WR, nn, a_r, 2'd2, 3'd4, 1'b1, 1'b0);
          gbls_pkg::OP_LD_HL_SPE: begin
            {r_nxt[4], r_nxt[5]} = spe;
            f_nxt = {2'b00, h_sum[4], c_sum[8]};
            res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd1, 3'd3, 1'b1, 1'b0);
          end
          gbls_pkg::OP_LD_SP_HL: begin
            sp_nxt = hl;
            res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd2, 1'b1, 1'b0);
          end
          default: res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd0, 1'b1, 1'b1);
        endcase
      end
    end else if (acc_in && kind && step_r != gbls_pkg::STEP_IDLE) begin
      push_one = 1'b1;
      if (gbls_pkg::is_pop(pop_r)) begin
        if (step_r == gbls_pkg::STEP_FIRST) begin
          if (pop_r[5:4] == 2'd3) f_nxt = dat[7:4];
          else r_nxt[{pop_r[5:4], 1'b1}] = dat;
          sp_nxt = sp_r + 16'd1;
          step_nxt = gbls_pkg::STEP_SECOND;
          res0 = gbls_pkg::mk_res(RD, sp_r, 8'h0, 2'd0, 3'd0, 1'b0, 1'b0);
        end else begin
          if (pop_r[5:4] == 2'd3) a_nxt = dat;
          else r_nxt[{pop_r[5:4], 1'b0}] = dat;
          step_nxt = gbls_pkg::STEP_IDLE;
          res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd3, 1'b1, 1'b0);
        end
      end else begin
        step_nxt = gbls_pkg::STEP_IDLE;
        if (pop_r[7:6] == 2'b01) begin
          if (pop_r[5:3] == 3'd7) a_nxt = dat;
          else if (pop_r[5:3] != 3'd6) r_nxt[pop_r[5:3]] = dat;
          res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd2, 1'b1, 1'b0);
        end else begin
          a_nxt = dat;
          if (pop_r == gbls_pkg::OP_LDH_A_N)
            res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd1, 3'd3, 1'b1, 1'b0);
          else if (pop_r == gbls_pkg::OP_LD_A_NN)
            res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd2, 3'd4, 1'b1, 1'b0);
          else
            res0 = gbls_pkg::mk_res(NONE, 16'h0, 8'h0, 2'd0, 3'd2, 1'b1, 1'b0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; f_r <= '0; sp_r <= '0; pop_r <= '0; step_r <= gbls_pkg::STEP_IDLE;
      for (int i = 0; i < 6; i++) r_r[i] <= '0;
    end else begin
      a_r <= a_nxt; f_r <= f_nxt; sp_r <= sp_nxt; pop_r <= pop_nxt; step_r <= step_nxt;
      for (int i = 0; i < 6; i++) r_r[i] <= r_nxt[i];
    end
  end

  gbls_out_buf u_buf (
    .clk(clk), .rst_n(rst_n), .push_one(push_one), .push_two(push_two),
    .res0(res0), .res1(res1), .room(room),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_res(ores)
  );

  assign out_tdata = {ores.not_load, ores.cycles, ores.imm_bytes, ores.write_data,
                      ores.address, ores.access};
  assign out_tlast = ores.done_res;

`ifndef SYNTHESIS
  a_step_op: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == gbls_pkg::STEP_IDLE || pop_r != 8'h00) else $error("pending step without op");
  a_second_pop: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == gbls_pkg::STEP_SECOND |-> gbls_pkg::is_pop(pop_r)) else $error("bad second step");
  a_instr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && !kind && !res0.access[0]) |=> step_r == gbls_pkg::STEP_IDLE)
    else $error("pending read kept");
`endif
endmodule

/* test/gbls_checker.sv */
// Checker for the load/store unit: watches both streams, predicts the bus results of
// every accepted item and compares them. Depends on gbls_pkg.
module gbls_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);

  logic [7:0]  cpu_a;
  logic [7:0]  cpu_r [6];
  logic [3:0]  cpu_f;
  logic [15:0] cpu_sp;
  logic [7:0]  wait_op;
  gbls_pkg::step_t wait_step;
  gbls_pkg::res_t  bus_q[$];

  assign pending_count = bus_q.size();

  function automatic logic [7:0] rd8(logic [2:0] c);
    if (c == 3'd7) return cpu_a;
    if (c == 3'd6) return 8'h00;
    return cpu_r[c];
  endfunction

  function automatic logic [15:0] pair(int i);
    return {cpu_r[2*i], cpu_r[2*i+1]};
  endfunction

  task automatic wr8(logic [2:0] c, logic [7:0] v);
    if (c == 3'd7) cpu_a = v;
    else if (c < 3'd6) cpu_r[c] = v;
  endtask

  task automatic set_pair(int i, logic [15:0] v);
    cpu_r[2*i] = v[15:8];
    cpu_r[2*i+1] = v[7:0];
  endtask

  task automatic push_res(logic [1:0] acc, logic [15:0] ad, logic [7:0] wd,
                          logic [1:0] imm, logic [2:0] cyc, logic dn, logic nl);
    gbls_pkg::res_t r;
    r.access = acc; r.address = ad; r.write_data = wd; r.imm_bytes = imm;
    r.cycles = cyc; r.done_res = dn; r.not_load = nl;
    bus_q.push_back(r);
  endtask

  task automatic begin_read(logic [7:0] op, logic [15:0] ad);
    wait_op = op;
    wait_step = gbls_pkg::STEP_FIRST;
    push_res(gbls_pkg::ACC_READ, ad, 0, 0, 0, 0, 0);
  endtask

  task automatic decode_op(logic [7:0] op, logic [7:0] n, logic [7:0] nh);
    logic [15:0] nn, hl, ext;
    logic [2:0]  d, s;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [7:0]  hi, lo;
    int i;
    nn = {nh, n};
    hl = pair(2);
    d = op[5:3];
    s = op[2:0];
    i = op[5:4];
    wait_step = gbls_pkg::STEP_IDLE;
    wait_op = 0;
    if (op[7:6] == 2'b01 && op != gbls_pkg::OP_HALT) begin
      if (d == 3'd6) push_res(gbls_pkg::ACC_WRITE, hl, rd8(s), 0, 2, 1, 0);
      else if (s == 3'd6) begin_read(op, hl);
      else begin
        wr8(d, rd8(s));
        push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 1, 1, 0);
      end
    end else if ((op & 8'hC7) == 8'h06 && op != gbls_pkg::OP_LD_MHL_N) begin
      wr8(d, n);
      push_res(gbls_pkg::ACC_NONE, 0, 0, 1, 2, 1, 0);
    end else if ((op & 8'hCF) == 8'h01) begin
      if (i == 3) cpu_sp = nn;
      else set_pair(i, nn);
      push_res(gbls_pkg::ACC_NONE, 0, 0, 2, 3, 1, 0);
    end else if (gbls_pkg::is_pop(op)) begin
      cpu_sp = cpu_sp + 16'd1;
      begin_read(op, cpu_sp - 16'd1);
    end else if ((op & 8'hCF) == 8'hC5) begin
      if (i == 3) begin
        hi = cpu_a; lo = {cpu_f, 4'h0};
      end else begin
        hi = cpu_r[2*i]; lo = cpu_r[2*i+1];
      end
      cpu_sp = cpu_sp - 16'd1;
      push_res(gbls_pkg::ACC_WRITE, cpu_sp, hi, 0, 0, 0, 0);
      cpu_sp = cpu_sp - 16'd1;
      push_res(gbls_pkg::ACC_WRITE, cpu_sp, lo, 0, 4, 1, 0);
    end else begin
      case (op)
        gbls_pkg::OP_LD_BC_A: push_res(gbls_pkg::ACC_WRITE, pair(0), cpu_a, 0, 2, 1, 0);
        gbls_pkg::OP_LD_DE_A: push_res(gbls_pkg::ACC_WRITE, pair(1), cpu_a, 0, 2, 1, 0);
        gbls_pkg::OP_LDI_HL_A: begin
          push_res(gbls_pkg::ACC_WRITE, hl, cpu_a, 0, 2, 1, 0);
          set_pair(2, hl + 16'd1);
        end
        gbls_pkg::OP_LDD_HL_A: begin
          push_res(gbls_pkg::ACC_WRITE, hl, cpu_a, 0, 2, 1, 0);
          set_pair(2, hl - 16'd1);
        end
        gbls_pkg::OP_LD_MHL_N: push_res(gbls_pkg::ACC_WRITE, hl, n, 1, 3, 1, 0);
        gbls_pkg::OP_LD_NN_SP: begin
          push_res(gbls_pkg::ACC_WRITE, nn, cpu_sp[7:0], 0, 0, 0, 0);
          push_res(gbls_pkg::ACC_WRITE, nn + 16'd1, cpu_sp[15:8], 2, 5, 1, 0);
        end
        gbls_pkg::OP_LD_A_BC: begin_read(op, pair(0));
        gbls_pkg::OP_LD_A_DE: begin_read(op, pair(1));
        gbls_pkg::OP_LDI_A_HL: begin
          set_pair(2, hl + 16'd1);
          begin_read(op, hl);
        end
        gbls_pkg::OP_LDD_A_HL: begin
          set_pair(2, hl - 16'd1);
          begin_read(op, hl);
        end
        gbls_pkg::OP_LDH_N_A:
          push_res(gbls_pkg::ACC_WRITE, gbls_pkg::HIGH_PAGE | n, cpu_a, 1, 3, 1, 0);
        gbls_pkg::OP_LDH_C_A:
          push_res(gbls_pkg::ACC_WRITE, gbls_pkg::HIGH_PAGE | cpu_r[1], cpu_a, 0, 2, 1, 0);
        gbls_pkg::OP_LD_NN_A: push_res(gbls_pkg::ACC_WRITE, nn, cpu_a, 2, 4, 1, 0);
        gbls_pkg::OP_LDH_A_N: begin_read(op, gbls_pkg::HIGH_PAGE | n);
        gbls_pkg::OP_LDH_A_C: begin_read(op, gbls_pkg::HIGH_PAGE | cpu_r[1]);
        gbls_pkg::OP_LD_A_NN: begin_read(op, nn);
        gbls_pkg::OP_LD_HL_SPE: begin
          ext = {{8{n[7]}}, n};
          sum4 = cpu_sp[3:0] + n[3:0];
          sum8 = cpu_sp[7:0] + n;
          set_pair(2, cpu_sp + ext);
          cpu_f = {2'b00, sum4[4], sum8[8]};
          push_res(gbls_pkg::ACC_NONE, 0, 0, 1, 3, 1, 0);
        end
        gbls_pkg::OP_LD_SP_HL: begin
          cpu_sp = hl;
          push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 2, 1, 0);
        end
        default: push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 0, 1, 1);
      endcase
    end
  endtask

  task automatic take_byte(logic [7:0] dat);
    int i;
    i = wait_op[5:4];
    if (gbls_pkg::is_pop(wait_op)) begin
      if (wait_step == gbls_pkg::STEP_FIRST) begin
        if (i == 3) cpu_f = dat[7:4];
        else cpu_r[2*i+1] = dat;
        cpu_sp = cpu_sp + 16'd1;
        wait_step = gbls_pkg::STEP_SECOND;
        push_res(gbls_pkg::ACC_READ, cpu_sp - 16'd1, 0, 0, 0, 0, 0);
      end else begin
        if (i == 3) cpu_a = dat;
        else cpu_r[2*i] = dat;
        wait_step = gbls_pkg::STEP_IDLE;
        push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 3, 1, 0);
      end
    end else begin
      wait_step = gbls_pkg::STEP_IDLE;
      if (wait_op[7:6] == 2'b01) begin
        wr8(wait_op[5:3], dat);
        push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 2, 1, 0);
      end else begin
        cpu_a = dat;
        if (wait_op == gbls_pkg::OP_LDH_A_N) push_res(gbls_pkg::ACC_NONE, 0, 0, 1, 3, 1, 0);
        else if (wait_op == gbls_pkg::OP_LD_A_NN)
          push_res(gbls_pkg::ACC_NONE, 0, 0, 2, 4, 1, 0);
        else push_res(gbls_pkg::ACC_NONE, 0, 0, 0, 2, 1, 0);
      end
    end
  endtask

  always @(posedge clk) begin
    gbls_pkg::res_t got, want;
    if (!rst_n) begin
      cpu_a <= 0;
      foreach (cpu_r[k]) cpu_r[k] <= 0;
      cpu_f <= 0;
      cpu_sp <= 0;
      wait_op <= 0;
      wait_step <= gbls_pkg::STEP_IDLE;
      bus_q.delete();
      fail_count <= 0;
    end else begin
      // compare first: results of this cycle's item appear only later
      if (out_tvalid && out_tready) begin
        got = gbls_pkg::res_t'({out_tlast, out_tdata});
        got.not_load = out_tdata[31];
        got.done_res = out_tlast;
        got.cycles = out_tdata[30:28];
        got.imm_bytes = out_tdata[27:26];
        got.write_data = out_tdata[25:18];
        got.address = out_tdata[17:2];
        got.access = out_tdata[1:0];
        if (bus_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = bus_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected acc %0d addr %h wd %h imm %0d cyc %0d dn %b nl %b",
                       want.access, want.address, want.write_data, want.imm_bytes,
                       want.cycles, want.done_res, want.not_load);
              $display("          got      acc %0d addr %h wd %h imm %0d cyc %0d dn %b nl %b",
                       got.access, got.address, got.write_data, got.imm_bytes,
                       got.cycles, got.done_res, got.not_load);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) decode_op(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
        else if (wait_step != gbls_pkg::STEP_IDLE) take_byte(in_tdata[31:24]);
      end
    end
  end

endmodule

/* test/tb_gb_cpu_load_store_unit.sv */
// Testbench top for gb_cpu_load_store_unit: drives instruction and read-data items
// with bursty gaps and a stalling result side; checking lives in gbls_checker.
module tb_gb_cpu_load_store_unit;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // opcode, imm_low, imm_high, read_data from bit 0 up
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // access, address, write_data, imm_bytes, cycles, not_load
  logic        out_tlast;  // done_res
  int          fail_count;
  int          pending_count;
  int          idle_cycles;

  localparam int WATCHDOG = 2000;

  gb_cpu_load_store_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  gbls_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: alternating modes, sometimes always ready.
  initial begin
    int mode, len;
    out_tready = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  int gap_left;

  // Hand over one item; random gaps before it depending on burst state.
  task automatic send(bit kind, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                      logic [7:0] rd);
    if (gap_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap_left = $urandom_range(1, 30);
    end
    gap_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {rd, hi, lo, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_op(logic [7:0] op);
    send(1'b0, op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte();
    send(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  function automatic int reads_of(logic [7:0] op);
    if (gbls_pkg::is_pop(op)) return 2;
    if (op[7:6] == 2'b01 && op != gbls_pkg::OP_HALT && op[2:0] == 3'd6 && op[5:3] != 3'd6)
      return 1;
    case (op)
      gbls_pkg::OP_LD_A_BC, gbls_pkg::OP_LD_A_DE, gbls_pkg::OP_LDI_A_HL,
      gbls_pkg::OP_LDD_A_HL, gbls_pkg::OP_LDH_A_N, gbls_pkg::OP_LDH_A_C,
      gbls_pkg::OP_LD_A_NN: return 1;
      default: return 0;
    endcase
  endfunction

  initial begin
    logic [7:0] op;
    int k, r;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = 0;
    gap_left = 5;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, stray data, push/pop AF, SP+e both signs, abandoned read
    send(1'b1, 8'h00, 8'h00, 8'h00, 8'hFF);                 // data while idle
    send(1'b0, 8'h31, 8'hFF, 8'hFF, 8'h00);                 // LD SP,FFFF
    send(1'b0, 8'h21, 8'h00, 8'h00, 8'hFF);                 // LD HL,0000
    send(1'b0, gbls_pkg::OP_LD_HL_SPE, 8'h01, 8'h00, 8'h00); // carries from FFFF+1
    send(1'b0, gbls_pkg::OP_LD_HL_SPE, 8'h80, 8'hFF, 8'h00); // negative offset
    send(1'b0, 8'hF5, 8'h00, 8'h00, 8'h00);                 // PUSH AF
    send(1'b0, 8'hF1, 8'h00, 8'h00, 8'h00);                 // POP AF
    send(1'b1, 8'h00, 8'h00, 8'h00, 8'hFF);
    send(1'b1, 8'h00, 8'h00, 8'h00, 8'hA5);
    send(1'b0, gbls_pkg::OP_LD_NN_SP, 8'hFF, 8'hFF, 8'h00);  // nn+1 wraps
    send(1'b0, gbls_pkg::OP_LDD_A_HL, 8'h00, 8'h00, 8'h00);  // HL counts down from FF7F
    send(1'b0, gbls_pkg::OP_LDH_A_N, 8'hFF, 8'h00, 8'h00);   // abandons the read
    send(1'b1, 8'h00, 8'h00, 8'h00, 8'h5A);
    send(1'b0, gbls_pkg::OP_LD_A_NN, 8'h34, 8'h12, 8'h00);
    send(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send(1'b0, gbls_pkg::OP_LD_NN_A, 8'hFF, 8'hFF, 8'h00);
    send(1'b0, gbls_pkg::OP_LDH_C_A, 8'h00, 8'h00, 8'h00);
    send(1'b0, gbls_pkg::OP_LDH_N_A, 8'h80, 8'h00, 8'h00);
    send(1'b0, gbls_pkg::OP_HALT, 8'hFF, 8'hFF, 8'hFF);
    send(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00);                 // not a load
    send(1'b0, gbls_pkg::OP_LD_MHL_N, 8'hFF, 8'h00, 8'h00);
    send(1'b0, gbls_pkg::OP_LD_SP_HL, 8'h00, 8'h00, 8'h00);

    // random: mostly complete instructions, some stray and missing data
    for (k = 0; k < 1750; k++) begin
      op = 8'($urandom_range(0, 255));
      send_op(op);
      r = reads_of(op);
      if ($urandom_range(0, 9) == 0 && r > 0) r = r - 1;
      repeat (r) send_byte();
      if ($urandom_range(0, 19) == 0) send_byte();
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
